@@ design/pthc_pkg.sv @@
package pthc_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 48;
    localparam int SIDE_W     = 39;
    localparam int INV_W      = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_LENGTH     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SIDE_LENGTH = 1'd1;

    localparam logic [INV_W-1:0] INV_RESET = 48'h0001_0000_0000;

    // 2/3, 1/3 and sqrt3/3 with 32 fraction bits, sqrt3 with 32 fraction bits
    localparam logic [31:0] K23  = 32'd2863311531;
    localparam logic [31:0] K13  = 32'd1431655765;
    localparam logic [31:0] KS3  = 32'd2479700525;
    localparam logic [32:0] KS3F = 33'd7439101574;

    localparam int AX_W    = 61;
    localparam int AX_FRAC = 24;

    localparam logic [AX_W-1:0] AX_MAX = {1'b0, {(AX_W-1){1'b1}}};
    localparam logic [AX_W-1:0] AX_MIN = {1'b1, {(AX_W-1){1'b0}}};

    localparam logic [AX_FRAC-1:0] FRAC_HALF = {1'b1, {(AX_FRAC-1){1'b0}}};

    localparam int IDX_W = 32;
    localparam logic [IDX_W-1:0] IDX_MAX = 32'h7fff_ffff;
    localparam logic [IDX_W-1:0] IDX_MIN = 32'h8000_0000;

    localparam int NSTG = 14;

endpackage

@@ design/pthc_in_if.sv @@
interface pthc_in_if #(
    parameter int COORD_WIDTH = 40
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;

    modport source (output valid, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

@@ design/pthc_out_if.sv @@
interface pthc_out_if #(
    parameter int COORD_WIDTH = 40
);
    logic                          valid;
    logic                          ready;
    logic signed [31:0]            cell_q;
    logic signed [31:0]            cell_r;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic                          overflow;

    modport source (output valid, output cell_q, output cell_r, output center_x,
                    output center_y, output overflow, input ready);
    modport sink   (input valid, input cell_q, input cell_r, input center_x,
                    input center_y, input overflow, output ready);
endinterface

@@ design/point_to_hex_cell.sv @@
// channel    dir  handshake      payload
// i_pt       in   valid/ready    pos_x, pos_y
// o_cell     out  valid/ready    cell_q, cell_r, center_x, center_y, overflow
// i_cfg_*    in   write enable   register index, write data
//
// one point per cycle unless a held result on o_cell stalls the pipeline
// a transfer in passes through 14 register stages of multiply, add, round and clamp steps
// a result held on o_cell with ready low freezes every stage and input ready
// reset clears the stage valid bits and loads side 1.0 and reciprocal 1.0
module point_to_hex_cell #(
    parameter int COORD_WIDTH     = 40,
    parameter int COORD_FRAC_BITS = 14
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [pthc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pthc_pkg::CFG_DATA_W-1:0]    i_cfg_wr_data,
    pthc_in_if.sink                            i_pt,
    pthc_out_if.source                         o_cell
);

    localparam int CW    = COORD_WIDTH;
    localparam int SHX   = COORD_FRAC_BITS + 8;
    localparam int NSTG  = pthc_pkg::NSTG;
    localparam int AXF   = pthc_pkg::AX_FRAC;
    localparam int SIDEW = pthc_pkg::SIDE_W;
    localparam int INVW  = pthc_pkg::INV_W;

    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [SIDEW-1:0] SIDE_RESET = {{(SIDEW-1){1'b0}}, 1'b1} << COORD_FRAC_BITS;

    function automatic logic signed [39:0] f_round(input logic signed [63:0] v);
        logic inc;
        inc = (v[AXF-1:0] > pthc_pkg::FRAC_HALF) ||
              ((v[AXF-1:0] == pthc_pkg::FRAC_HALF) && !v[63]);
        return $signed(v[63:AXF]) + $signed({39'd0, inc});
    endfunction

    function automatic logic [AXF-1:0] f_err(input logic signed [63:0] v);
        return v[AXF-1] ? (~v[AXF-1:0] + 24'd1) : v[AXF-1:0];
    endfunction

    logic [SIDEW-1:0] r_side;
    logic [INVW-1:0]  r_inv;
    logic [NSTG-1:0]  r_vld;
    logic             w_en;

    assign w_en       = !r_vld[NSTG-1] || o_cell.ready;
    assign i_pt.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= SIDE_RESET;
            r_inv  <= pthc_pkg::INV_RESET;
            r_vld  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_idx)
                    pthc_pkg::CFG_SIDE_LENGTH:     r_side <= i_cfg_wr_data[SIDEW-1:0];
                    pthc_pkg::CFG_INV_SIDE_LENGTH: r_inv  <= i_cfg_wr_data[INVW-1:0];
                endcase
            end
            if (w_en) begin
                r_vld <= {r_vld[NSTG-2:0], i_pt.valid};
            end
        end
    end

    // stage a: point times reciprocal, four partial products per axis
    logic signed [63:0] w_px, w_py;
    logic [55:0]        w_a_xll, w_a_xlh, w_a_yll, w_a_ylh;
    logic signed [56:0] w_a_xhl, w_a_xhh, w_a_yhl, w_a_yhh;
    logic [55:0]        r_a_xll, r_a_xlh, r_a_yll, r_a_ylh;
    logic signed [56:0] r_a_xhl, r_a_xhh, r_a_yhl, r_a_yhh;

    assign w_px    = i_pt.pos_x;
    assign w_py    = i_pt.pos_y;
    assign w_a_xll = w_px[31:0] * r_inv[23:0];
    assign w_a_xlh = w_px[31:0] * r_inv[47:24];
    assign w_a_xhl = $signed(w_px[63:32]) * $signed({1'b0, r_inv[23:0]});
    assign w_a_xhh = $signed(w_px[63:32]) * $signed({1'b0, r_inv[47:24]});
    assign w_a_yll = w_py[31:0] * r_inv[23:0];
    assign w_a_ylh = w_py[31:0] * r_inv[47:24];
    assign w_a_yhl = $signed(w_py[63:32]) * $signed({1'b0, r_inv[23:0]});
    assign w_a_yhh = $signed(w_py[63:32]) * $signed({1'b0, r_inv[47:24]});

    // stage b: pair the partial products
    logic signed [80:0] w_b_xhl, w_b_xhh, w_b_yhl, w_b_yhh;
    logic [79:0]        n_b_xlo, n_b_ylo, r_b_xlo, r_b_ylo;
    logic signed [80:0] n_b_xhi, n_b_yhi, r_b_xhi, r_b_yhi;

    assign w_b_xhl = r_a_xhl;
    assign w_b_xhh = r_a_xhh;
    assign w_b_yhl = r_a_yhl;
    assign w_b_yhh = r_a_yhh;
    assign n_b_xlo = {24'd0, r_a_xll} + {r_a_xlh, 24'd0};
    assign n_b_ylo = {24'd0, r_a_yll} + {r_a_ylh, 24'd0};
    assign n_b_xhi = w_b_xhl + (w_b_xhh <<< 24);
    assign n_b_yhi = w_b_yhl + (w_b_yhh <<< 24);

    // stage c: full product, scale to 24 fraction bits, clamp
    logic signed [112:0] w_c_tx, w_c_ty, w_c_sx, w_c_sy;
    logic                w_c_ovx, w_c_ovy;
    logic signed [60:0]  n_c_ax, n_c_by, r_c_ax, r_c_by;
    logic                r_c_ov;

    assign w_c_tx  = {r_b_xhi, 32'd0} + {33'd0, r_b_xlo};
    assign w_c_ty  = {r_b_yhi, 32'd0} + {33'd0, r_b_ylo};
    assign w_c_sx  = w_c_tx >>> SHX;
    assign w_c_sy  = w_c_ty >>> SHX;
    assign w_c_ovx = w_c_sx[112:60] != {53{w_c_sx[112]}};
    assign w_c_ovy = w_c_sy[112:60] != {53{w_c_sy[112]}};
    assign n_c_ax  = w_c_ovx ? (w_c_sx[112] ? pthc_pkg::AX_MIN : pthc_pkg::AX_MAX)
                             : w_c_sx[60:0];
    assign n_c_by  = w_c_ovy ? (w_c_sy[112] ? pthc_pkg::AX_MIN : pthc_pkg::AX_MAX)
                             : w_c_sy[60:0];

    // stage d: constant products for the axial transform
    logic [63:0]        r_d_qlo, r_d_alo, r_d_blo;
    logic signed [61:0] r_d_qhi, r_d_ahi, r_d_bhi;
    logic               r_d_ov;
    logic [63:0]        n_d_qlo, n_d_alo, n_d_blo;
    logic signed [61:0] n_d_qhi, n_d_ahi, n_d_bhi;

    assign n_d_qlo = r_c_ax[31:0] * pthc_pkg::K23;
    assign n_d_alo = r_c_ax[31:0] * pthc_pkg::K13;
    assign n_d_blo = r_c_by[31:0] * pthc_pkg::KS3;
    assign n_d_qhi = $signed(r_c_ax[60:32]) * $signed({1'b0, pthc_pkg::K23});
    assign n_d_ahi = $signed(r_c_ax[60:32]) * $signed({1'b0, pthc_pkg::K13});
    assign n_d_bhi = $signed(r_c_by[60:32]) * $signed({1'b0, pthc_pkg::KS3});

    // stage e: fractional q and r
    logic signed [63:0] w_e_qhi, w_e_qlo, w_e_ahi, w_e_bhi, w_e_dhi;
    logic signed [64:0] w_e_d;
    logic signed [63:0] n_e_fq, n_e_fr, r_e_fq, r_e_fr;
    logic               r_e_ov;

    assign w_e_qhi = r_d_qhi;
    assign w_e_qlo = {32'd0, r_d_qlo[63:32]};
    assign w_e_ahi = r_d_ahi;
    assign w_e_bhi = r_d_bhi;
    assign w_e_d   = {1'b0, r_d_blo} - {1'b0, r_d_alo};
    assign w_e_dhi = $signed(w_e_d[64:32]);
    assign n_e_fq  = w_e_qhi + w_e_qlo;
    assign n_e_fr  = w_e_bhi - w_e_ahi + w_e_dhi;

    // stage f: third cube coordinate
    logic signed [63:0] n_f_fs, r_f_fq, r_f_fr, r_f_fs;
    logic               r_f_ov;

    assign n_f_fs = -r_e_fq - r_e_fr;

    // stage g: round and measure distance to nearest integer
    logic signed [39:0] r_g_rq, r_g_rr, r_g_rs;
    logic [AXF-1:0]     r_g_dq, r_g_dr, r_g_ds;
    logic               r_g_ov;

    // stage h: fix the coordinate with the largest error, saturate
    logic signed [39:0] w_h_q, w_h_r;
    logic               w_h_sq, w_h_sr;
    logic signed [31:0] n_h_q, n_h_r, r_h_q, r_h_r;
    logic               r_h_ov;

    always_comb begin
        w_h_q = r_g_rq;
        w_h_r = r_g_rr;
        priority if (r_g_dq > r_g_dr && r_g_dq > r_g_ds) begin
            w_h_q = -r_g_rr - r_g_rs;
        end else if (r_g_dr > r_g_ds) begin
            w_h_r = -r_g_rq - r_g_rs;
        end else begin
            w_h_q = r_g_rq;
        end
    end

    assign w_h_sq = w_h_q[39:31] != {9{w_h_q[39]}};
    assign w_h_sr = w_h_r[39:31] != {9{w_h_r[39]}};
    assign n_h_q  = w_h_sq ? (w_h_q[39] ? pthc_pkg::IDX_MIN : pthc_pkg::IDX_MAX)
                           : w_h_q[31:0];
    assign n_h_r  = w_h_sr ? (w_h_r[39] ? pthc_pkg::IDX_MIN : pthc_pkg::IDX_MAX)
                           : w_h_r[31:0];

    // stage i: 3q and 2r+q
    logic signed [33:0] w_i_q, w_i_r, n_i_m3, n_i_m2, r_i_m3, r_i_m2;
    logic signed [31:0] r_i_q, r_i_r;
    logic               r_i_ov;

    assign w_i_q  = r_h_q;
    assign w_i_r  = r_h_r;
    assign n_i_m3 = w_i_q + (w_i_q <<< 1);
    assign n_i_m2 = w_i_q + (w_i_r <<< 1);

    // stage j: times side, split side in two
    logic signed [54:0] n_j_xlo, n_j_ylo, r_j_xlo, r_j_ylo;
    logic signed [53:0] n_j_xhi, n_j_yhi, r_j_xhi, r_j_yhi;
    logic signed [31:0] r_j_q, r_j_r;
    logic               r_j_ov;

    assign n_j_xlo = r_i_m3 * $signed({1'b0, r_side[19:0]});
    assign n_j_xhi = r_i_m3 * $signed({1'b0, r_side[38:20]});
    assign n_j_ylo = r_i_m2 * $signed({1'b0, r_side[19:0]});
    assign n_j_yhi = r_i_m2 * $signed({1'b0, r_side[38:20]});

    // stage k: join side products
    logic signed [72:0] w_k_xlo, w_k_xhi, w_k_ylo, w_k_yhi;
    logic signed [72:0] n_k_cx, n_k_cy, r_k_cx, r_k_cy;
    logic signed [31:0] r_k_q, r_k_r;
    logic               r_k_ov;

    assign w_k_xlo = r_j_xlo;
    assign w_k_xhi = r_j_xhi;
    assign w_k_ylo = r_j_ylo;
    assign w_k_yhi = r_j_yhi;
    assign n_k_cx  = w_k_xlo + (w_k_xhi <<< 20);
    assign n_k_cy  = w_k_ylo + (w_k_yhi <<< 20);

    // stage l: center x clamp, center y times sqrt3 in three pieces
    logic signed [72:0]   w_l_cxs;
    logic                 w_l_sat;
    logic signed [CW-1:0] n_l_cx, r_l_cx;
    logic [57:0]          n_l_p0, n_l_p1, r_l_p0, r_l_p1;
    logic signed [56:0]   n_l_p2, r_l_p2;
    logic signed [31:0]   r_l_q, r_l_r;
    logic                 r_l_ov;

    assign w_l_cxs = r_k_cx >>> 1;
    assign w_l_sat = w_l_cxs[72:CW-1] != {(74-CW){w_l_cxs[72]}};
    assign n_l_cx  = w_l_sat ? (w_l_cxs[72] ? CMIN : CMAX) : w_l_cxs[CW-1:0];
    assign n_l_p0  = r_k_cy[24:0] * pthc_pkg::KS3F;
    assign n_l_p1  = r_k_cy[49:25] * pthc_pkg::KS3F;
    assign n_l_p2  = $signed(r_k_cy[72:50]) * $signed({1'b0, pthc_pkg::KS3F});

    // stage m: sum of center y pieces
    logic signed [105:0]  w_m_p2, n_m_cy, r_m_cy;
    logic signed [CW-1:0] r_m_cx;
    logic signed [31:0]   r_m_q, r_m_r;
    logic                 r_m_ov;

    assign w_m_p2 = r_l_p2;
    assign n_m_cy = (w_m_p2 <<< 50) + {23'd0, r_l_p1, 25'd0} + {48'd0, r_l_p0};

    // stage n: center y scale and clamp, output register
    logic signed [105:0]  w_n_cys;
    logic                 w_n_sat;
    logic signed [CW-1:0] n_n_cy, r_n_cy, r_n_cx;
    logic signed [31:0]   r_n_q, r_n_r;
    logic                 r_n_ov;

    assign w_n_cys = r_m_cy >>> 33;
    assign w_n_sat = w_n_cys[105:CW-1] != {(107-CW){w_n_cys[105]}};
    assign n_n_cy  = w_n_sat ? (w_n_cys[105] ? CMIN : CMAX) : w_n_cys[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_xll <= w_a_xll;
            r_a_xlh <= w_a_xlh;
            r_a_xhl <= w_a_xhl;
            r_a_xhh <= w_a_xhh;
            r_a_yll <= w_a_yll;
            r_a_ylh <= w_a_ylh;
            r_a_yhl <= w_a_yhl;
            r_a_yhh <= w_a_yhh;

            r_b_xlo <= n_b_xlo;
            r_b_ylo <= n_b_ylo;
            r_b_xhi <= n_b_xhi;
            r_b_yhi <= n_b_yhi;

            r_c_ax  <= n_c_ax;
            r_c_by  <= n_c_by;
            r_c_ov  <= w_c_ovx || w_c_ovy;

            r_d_qlo <= n_d_qlo;
            r_d_alo <= n_d_alo;
            r_d_blo <= n_d_blo;
            r_d_qhi <= n_d_qhi;
            r_d_ahi <= n_d_ahi;
            r_d_bhi <= n_d_bhi;
            r_d_ov  <= r_c_ov;

            r_e_fq  <= n_e_fq;
            r_e_fr  <= n_e_fr;
            r_e_ov  <= r_d_ov;

            r_f_fq  <= r_e_fq;
            r_f_fr  <= r_e_fr;
            r_f_fs  <= n_f_fs;
            r_f_ov  <= r_e_ov;

            r_g_rq  <= f_round(r_f_fq);
            r_g_rr  <= f_round(r_f_fr);
            r_g_rs  <= f_round(r_f_fs);
            r_g_dq  <= f_err(r_f_fq);
            r_g_dr  <= f_err(r_f_fr);
            r_g_ds  <= f_err(r_f_fs);
            r_g_ov  <= r_f_ov;

            r_h_q   <= n_h_q;
            r_h_r   <= n_h_r;
            r_h_ov  <= r_g_ov || w_h_sq || w_h_sr;

            r_i_m3  <= n_i_m3;
            r_i_m2  <= n_i_m2;
            r_i_q   <= r_h_q;
            r_i_r   <= r_h_r;
            r_i_ov  <= r_h_ov;

            r_j_xlo <= n_j_xlo;
            r_j_xhi <= n_j_xhi;
            r_j_ylo <= n_j_ylo;
            r_j_yhi <= n_j_yhi;
            r_j_q   <= r_i_q;
            r_j_r   <= r_i_r;
            r_j_ov  <= r_i_ov;

            r_k_cx  <= n_k_cx;
            r_k_cy  <= n_k_cy;
            r_k_q   <= r_j_q;
            r_k_r   <= r_j_r;
            r_k_ov  <= r_j_ov;

            r_l_cx  <= n_l_cx;
            r_l_p0  <= n_l_p0;
            r_l_p1  <= n_l_p1;
            r_l_p2  <= n_l_p2;
            r_l_q   <= r_k_q;
            r_l_r   <= r_k_r;
            r_l_ov  <= r_k_ov || w_l_sat;

            r_m_cy  <= n_m_cy;
            r_m_cx  <= r_l_cx;
            r_m_q   <= r_l_q;
            r_m_r   <= r_l_r;
            r_m_ov  <= r_l_ov;

            r_n_cy  <= n_n_cy;
            r_n_cx  <= r_m_cx;
            r_n_q   <= r_m_q;
            r_n_r   <= r_m_r;
            r_n_ov  <= r_m_ov || w_n_sat;
        end
    end

    assign o_cell.valid    = r_vld[NSTG-1];
    assign o_cell.cell_q   = r_n_q;
    assign o_cell.cell_r   = r_n_r;
    assign o_cell.center_x = r_n_cx;
    assign o_cell.center_y = r_n_cy;
    assign o_cell.overflow = r_n_ov;

`ifndef ASSERT_OFF
    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pt.ready |-> (o_cell.valid && !o_cell.ready))
        else $error("input stalled without a held result");

    a_first_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && w_en) |=> r_vld[1])
        else $error("item lost leaving first stage");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved during stall");
`endif

endmodule
